@@ hw/rtl/rwd_pkg.sv @@
`default_nettype none

package rwd_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [5:0]  LAST_VALID_CHANNEL_RST = 6'd36;
  localparam logic [4:0]  LAST_VALID_ROC_RST     = 5'd2;
  localparam logic [31:0] DAY_LENGTH_RST         = 32'd86400000;

  localparam logic [1:0] REQ_HEADER  = 2'd0;
  localparam logic [1:0] REQ_DATA    = 2'd1;
  localparam logic [1:0] REQ_TRAILER = 2'd2;

  localparam logic [1:0] REG_LAST_VALID_CHANNEL = 2'd0;
  localparam logic [1:0] REG_LAST_VALID_ROC     = 2'd1;
  localparam logic [1:0] REG_DAY_LENGTH         = 2'd2;

  typedef enum logic [3:0] {
    KIND_HIT         = 4'd0,
    KIND_GAP         = 4'd1,
    KIND_DUMMY       = 4'd2,
    KIND_NEARFULL    = 4'd3,
    KIND_TIMEOUT_W1  = 4'd4,
    KIND_TIMEOUT_W2  = 4'd5,
    KIND_TIMEOUT_OTH = 4'd6,
    KIND_TRAILER_ERR = 4'd7,
    KIND_EVNUM_ERR   = 4'd8,
    KIND_ALL_ONES    = 4'd9,
    KIND_BAD_ROC     = 4'd10,
    KIND_BAD_CHANNEL = 4'd11,
    KIND_NULL        = 4'd12,
    KIND_DUPLICATE   = 4'd13,
    KIND_TRAILER     = 4'd14,
    KIND_HEADER      = 4'd15
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  channel;
    logic [1:0]  roc_index;
    logic [5:0]  column;
    logic [6:0]  row;
    logic [35:0] detail;
    logic [31:0] word;
  } item_t;

endpackage

`default_nettype wire

@@ hw/rtl/rwd_fifo.sv @@
`default_nettype none

module rwd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rwd_front.sv @@
`default_nettype none

module rwd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    req_type,
  input  wire logic [31:0]   word,
  input  wire logic [5:0]    last_valid_channel,
  input  wire logic [4:0]    last_valid_roc,
  output logic               q_push,
  output rwd_pkg::item_t     q_item,
  input  wire logic          q_full
);

  import rwd_pkg::*;

  logic        f_valid;
  item_t       f_item;
  item_t       item_next;
  logic        accept;
  logic [31:0] history_words [2];
  logic [1:0]  history_valid;
  logic        dup;
  logic [4:0]  roc;
  logic [4:0]  roc_idx;
  logic [7:0]  pix;
  logic [7:0]  half;
  logic [7:0]  sel;

  function automatic logic [5:0] timeout_offset(input logic [2:0] code);
    logic [5:0] off;
    case (code)
      3'd0:    off = 6'd0;
      3'd1:    off = 6'd4;
      3'd2:    off = 6'd9;
      3'd3:    off = 6'd13;
      3'd4:    off = 6'd18;
      3'd5:    off = 6'd22;
      3'd6:    off = 6'd27;
      default: off = 6'd31;
    endcase
    return off;
  endfunction

  assign full   = f_valid && q_full;
  assign accept = push && !full;
  assign q_push = f_valid && !q_full;
  assign q_item = f_item;

  assign dup     = history_valid[1] && (history_words[1] == word);
  assign roc     = word[25:21];
  assign roc_idx = roc - 5'd1;
  assign pix     = word[15:8];
  assign half    = {1'b0, pix[7:1]};
  assign sel     = word[27:20];

  always_comb begin
    item_next           = '0;
    item_next.kind      = KIND_NULL;
    item_next.word      = word;
    if (req_type == REQ_HEADER) begin
      item_next.kind = KIND_HEADER;
    end else if (req_type == REQ_TRAILER) begin
      item_next.kind = KIND_TRAILER;
    end else begin
      item_next.channel = word[31:26];
      if (dup) begin
        item_next.kind = KIND_DUPLICATE;
      end else if (word[27:0] == 28'd0) begin
        item_next.kind = KIND_NULL;
      end else if (roc > 5'd25) begin
        if (word == 32'hffff_ffff) begin
          item_next.kind = KIND_ALL_ONES;
        end else begin
          case (roc)
            5'd26:   item_next.kind = KIND_GAP;
            5'd27:   item_next.kind = KIND_DUMMY;
            5'd28:   item_next.kind = KIND_NEARFULL;
            5'd29: begin
              if (sel == 8'h3b) begin
                item_next.kind = KIND_TIMEOUT_W1;
              end else if (sel == 8'h3a) begin
                item_next.kind   = KIND_TIMEOUT_W2;
                item_next.detail = 36'(word[4:0]) << timeout_offset(word[10:8]);
              end else begin
                item_next.kind = KIND_TIMEOUT_OTH;
              end
            end
            5'd30: begin
              item_next.kind   = KIND_TRAILER_ERR;
              item_next.detail = 36'(word[11:0]);
            end
            default: begin
              item_next.kind   = KIND_EVNUM_ERR;
              item_next.detail = 36'(word[7:0]);
            end
          endcase
        end
      end else if (word[31:26] != 6'd0 && word[31:26] <= last_valid_channel) begin
        if (roc != 5'd0 && roc_idx <= last_valid_roc) begin
          item_next.kind      = KIND_HIT;
          item_next.roc_index = roc_idx[1:0];
          item_next.column    = {word[20:16], pix[0]};
          if (pix == 8'd160 || pix == 8'd161) begin
            item_next.row = 7'd0;
          end else if (half >= 8'd80) begin
            item_next.row = 7'(half - 8'd80);
          end else begin
            item_next.row = 7'(8'd80 - half);
          end
        end else begin
          item_next.kind = KIND_BAD_ROC;
        end
      end else begin
        item_next.kind = KIND_BAD_CHANNEL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid          <= 1'b0;
      history_valid    <= 2'b00;
      history_words[0] <= '0;
      history_words[1] <= '0;
    end else begin
      if (accept) begin
        f_valid <= 1'b1;
      end else if (q_push) begin
        f_valid <= 1'b0;
      end
      if (accept && req_type == REQ_HEADER) begin
        history_valid    <= 2'b00;
        history_words[0] <= '0;
        history_words[1] <= '0;
      end else if (accept && req_type != REQ_TRAILER) begin
        history_valid    <= {history_valid[0], 1'b1};
        history_words[0] <= word;
        history_words[1] <= history_words[0];
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rwd_back.sv @@
`default_nettype none

module rwd_back #(
  parameter int COUNT_WIDTH = rwd_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire rwd_pkg::item_t q_item,
  output logic                q_pop,
  input  wire logic [31:0]    day_length,
  output logic                empty,
  input  wire logic           pop,
  output logic [3:0]          kind,
  output logic [5:0]          channel,
  output logic [1:0]          roc_index,
  output logic [5:0]          column,
  output logic [6:0]          row,
  output logic [35:0]         detail,
  output logic [15:0]         hit_count,
  output logic [15:0]         gap_count,
  output logic [15:0]         timeout_count,
  output logic [15:0]         evnum_err_count,
  output logic [15:0]         other_err_count,
  output logic [31:0]         extended_time
);

  import rwd_pkg::*;

  logic [COUNT_WIDTH-1:0] hits_seen, gaps_seen, timeouts_seen;
  logic [COUNT_WIDTH-1:0] evnum_errors_seen, other_errors_seen;
  logic [COUNT_WIDTH-1:0] hits_next, gaps_next, timeouts_next;
  logic [COUNT_WIDTH-1:0] evnum_next, other_next;
  logic [31:0]            previous_time, wrap_count, wrap_next;

  logic                   a_valid, b_valid, a_load, b_load;
  item_t                  a_item;
  logic [COUNT_WIDTH-1:0] a_hits, a_gaps, a_timeouts, a_evnum, a_other;
  logic [31:0]            a_wrap;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  assign empty  = !b_valid;
  assign b_load = a_valid && (!b_valid || pop);
  assign a_load = q_valid && (!a_valid || b_load);
  assign q_pop  = a_load;

  always_comb begin
    hits_next     = hits_seen;
    gaps_next     = gaps_seen;
    timeouts_next = timeouts_seen;
    evnum_next    = evnum_errors_seen;
    other_next    = other_errors_seen;
    wrap_next     = wrap_count;
    case (q_item.kind)
      KIND_HIT:         hits_next = sat_inc(hits_seen);
      KIND_GAP,
      KIND_DUMMY:       gaps_next = sat_inc(gaps_seen);
      KIND_TIMEOUT_W1,
      KIND_TIMEOUT_W2,
      KIND_TIMEOUT_OTH: timeouts_next = sat_inc(timeouts_seen);
      KIND_EVNUM_ERR:   evnum_next = sat_inc(evnum_errors_seen);
      KIND_NEARFULL,
      KIND_TRAILER_ERR,
      KIND_ALL_ONES,
      KIND_BAD_ROC,
      KIND_BAD_CHANNEL,
      KIND_NULL:        other_next = sat_inc(other_errors_seen);
      KIND_HEADER: begin
        hits_next     = '0;
        gaps_next     = '0;
        timeouts_next = '0;
        evnum_next    = '0;
        other_next    = '0;
      end
      KIND_TRAILER: begin
        if ($signed(q_item.word) < $signed(previous_time)) begin
          wrap_next = wrap_count + 32'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits_seen         <= '0;
      gaps_seen         <= '0;
      timeouts_seen     <= '0;
      evnum_errors_seen <= '0;
      other_errors_seen <= '0;
      previous_time     <= 32'hffff_ffff;
      wrap_count        <= '0;
      a_valid           <= 1'b0;
      b_valid           <= 1'b0;
    end else begin
      if (a_load) begin
        hits_seen         <= hits_next;
        gaps_seen         <= gaps_next;
        timeouts_seen     <= timeouts_next;
        evnum_errors_seen <= evnum_next;
        other_errors_seen <= other_next;
        wrap_count        <= wrap_next;
        if (q_item.kind == KIND_TRAILER) begin
          previous_time <= q_item.word;
        end
      end
      if (a_load) begin
        a_valid <= 1'b1;
      end else if (b_load) begin
        a_valid <= 1'b0;
      end
      if (b_load) begin
        b_valid <= 1'b1;
      end else if (pop) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_item     <= q_item;
      a_hits     <= hits_next;
      a_gaps     <= gaps_next;
      a_timeouts <= timeouts_next;
      a_evnum    <= evnum_next;
      a_other    <= other_next;
      a_wrap     <= wrap_next;
    end
    if (b_load) begin
      kind            <= a_item.kind;
      channel         <= a_item.channel;
      roc_index       <= a_item.roc_index;
      column          <= a_item.column;
      row             <= a_item.row;
      detail          <= a_item.detail;
      hit_count       <= 16'(a_hits);
      gap_count       <= 16'(a_gaps);
      timeout_count   <= 16'(a_timeouts);
      evnum_err_count <= 16'(a_evnum);
      other_err_count <= 16'(a_other);
      extended_time   <= (a_item.kind == KIND_TRAILER) ?
                         a_item.word + 32'(day_length * a_wrap) : 32'd0;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/readout_word_decoder.sv @@
// Readout word decoder.
// Input channel: push/full carries one tagged word (req_type, word) per cycle
// while full is low: event header, data word or trailer time. Result channel:
// empty/pop; exactly one result per input word, in order, while empty is low.
// Configuration over the APB port: last_valid_channel at 0x0, last_valid_roc
// at 0x4, day_length at 0x8; write only while the block is idle.
// Throughput: one word per cycle sustained while pop is held high. The front
// stage classifies the word and checks duplicates in its accept cycle; the
// back stage updates the saturating counters and wrap count, then a
// multiply-add stage extends the trailer time. An accepted word passes the
// front register, the queue, the counter stage and the result register.
// When the receiver stalls, results collect in the back stages and the queue;
// full rises once the queue and the front register are occupied.
// Reset (synchronous, rst high) empties all stages, clears counters and
// history, sets the previous trailer time to all ones and restores the
// register defaults.
`default_nettype none

module readout_word_decoder #(
  parameter int COUNT_WIDTH = rwd_pkg::COUNT_WIDTH_DEF,
  parameter int FIFO_DEPTH  = rwd_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] word,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       kind,
  output logic [5:0]       channel,
  output logic [1:0]       roc_index,
  output logic [5:0]       column,
  output logic [6:0]       row,
  output logic [35:0]      detail,
  output logic [15:0]      hit_count,
  output logic [15:0]      gap_count,
  output logic [15:0]      timeout_count,
  output logic [15:0]      evnum_err_count,
  output logic [15:0]      other_err_count,
  output logic [31:0]      extended_time,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import rwd_pkg::*;

  logic [5:0]  last_valid_channel;
  logic [4:0]  last_valid_roc;
  logic [31:0] day_length;
  logic        cfg_wr;
  logic        q_push, q_full, q_valid, q_pop;
  item_t       f_item;
  item_t       q_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid_channel <= LAST_VALID_CHANNEL_RST;
      last_valid_roc     <= LAST_VALID_ROC_RST;
      day_length         <= DAY_LENGTH_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LAST_VALID_CHANNEL: last_valid_channel <= pwdata[5:0];
        REG_LAST_VALID_ROC:     last_valid_roc     <= pwdata[4:0];
        REG_DAY_LENGTH:         day_length         <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LAST_VALID_CHANNEL: prdata = {26'd0, last_valid_channel};
      REG_LAST_VALID_ROC:     prdata = {27'd0, last_valid_roc};
      REG_DAY_LENGTH:         prdata = day_length;
      default:                prdata = 32'd0;
    endcase
  end

  rwd_front u_front (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .req_type           (req_type),
    .word               (word),
    .last_valid_channel (last_valid_channel),
    .last_valid_roc     (last_valid_roc),
    .q_push             (q_push),
    .q_item             (f_item),
    .q_full             (q_full)
  );

  rwd_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (f_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_item),
    .valid   (q_valid)
  );

  rwd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .day_length      (day_length),
    .empty           (empty),
    .pop             (pop),
    .kind            (kind),
    .channel         (channel),
    .roc_index       (roc_index),
    .column          (column),
    .row             (row),
    .detail          (detail),
    .hit_count       (hit_count),
    .gap_count       (gap_count),
    .timeout_count   (timeout_count),
    .evnum_err_count (evnum_err_count),
    .other_err_count (other_err_count),
    .extended_time   (extended_time)
  );

endmodule

`default_nettype wire

@@ dv/readout_word_decoder_test.sv @@
`timescale 1ns / 100ps

module readout_word_decoder_test;
  import rwd_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;

  localparam logic [4:0] ROC_LAST_PIXEL = 5'd25;
  localparam logic [4:0] ROC_GAP        = 5'd26;
  localparam logic [4:0] ROC_DUMMY      = 5'd27;
  localparam logic [4:0] ROC_NEARFULL   = 5'd28;
  localparam logic [4:0] ROC_TIMEOUT    = 5'd29;
  localparam logic [4:0] ROC_TRAILER    = 5'd30;
  localparam logic [4:0] ROC_EVNUM      = 5'd31;

  localparam logic [7:0] TIMEOUT_W1_SEL = 8'h3B;
  localparam logic [7:0] TIMEOUT_W2_SEL = 8'h3A;

  localparam int TIMEOUT_OFFSET [8] = '{0, 4, 9, 13, 18, 22, 27, 31};

  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [3:0]  kind;
    logic [5:0]  channel;
    logic [1:0]  roc_index;
    logic [5:0]  column;
    logic [6:0]  row;
    logic [35:0] detail;
    logic [15:0] hits;
    logic [15:0] gaps;
    logic [15:0] timeouts;
    logic [15:0] evnum_errs;
    logic [15:0] other_errs;
    logic [31:0] ext_time;
  } decoded_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        push     = 1'b0;
  logic [1:0]  req_type = REQ_HEADER;
  logic [31:0] word     = '0;
  logic        pop      = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;

  logic        full;
  logic        empty;
  logic [3:0]  kind;
  logic [5:0]  channel;
  logic [1:0]  roc_index;
  logic [5:0]  column;
  logic [6:0]  row;
  logic [35:0] detail;
  logic [15:0] hit_count;
  logic [15:0] gap_count;
  logic [15:0] timeout_count;
  logic [15:0] evnum_err_count;
  logic [15:0] other_err_count;
  logic [31:0] extended_time;
  logic [31:0] prdata;
  logic        pready;

  readout_word_decoder dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .req_type        (req_type),
    .word            (word),
    .empty           (empty),
    .pop             (pop),
    .kind            (kind),
    .channel         (channel),
    .roc_index       (roc_index),
    .column          (column),
    .row             (row),
    .detail          (detail),
    .hit_count       (hit_count),
    .gap_count       (gap_count),
    .timeout_count   (timeout_count),
    .evnum_err_count (evnum_err_count),
    .other_err_count (other_err_count),
    .extended_time   (extended_time),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // decoder shadow state
  logic [5:0]  max_channel  = LAST_VALID_CHANNEL_RST;
  logic [4:0]  max_roc      = LAST_VALID_ROC_RST;
  logic [31:0] day_len      = DAY_LENGTH_RST;
  logic [15:0] hits_seen    = '0;
  logic [15:0] gaps_seen    = '0;
  logic [15:0] tmo_seen     = '0;
  logic [15:0] evnum_seen   = '0;
  logic [15:0] other_seen   = '0;
  logic [31:0] back_one     = '0;
  logic [31:0] back_two     = '0;
  logic [1:0]  back_valid   = '0;
  logic [31:0] prev_time    = 32'hFFFF_FFFF;
  logic [31:0] wraps        = '0;

  decoded_t    pending_results[$];
  int          mismatch_count = 0;
  int          pop_wait       = 0;
  bit          tx_quiet       = 1'b0;
  bit          rx_quiet       = 1'b0;
  bit          hold_req       = 1'b0;
  bit          hold_off       = 1'b0;
  logic [31:0] trailer_clock  = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c == '1) ? c : c + 16'd1;
  endfunction

  function automatic decoded_t decode_word(input logic [1:0] t, input logic [31:0] w);
    decoded_t   r;
    logic       dup;
    logic [4:0] roc;
    logic [4:0] idx;
    logic [7:0] pix;
    logic [6:0] half;
    int         off;
    r = '0;
    r.kind = KIND_NULL;
    if (t == REQ_HEADER) begin
      hits_seen  = '0;
      gaps_seen  = '0;
      tmo_seen   = '0;
      evnum_seen = '0;
      other_seen = '0;
      back_one   = '0;
      back_two   = '0;
      back_valid = '0;
      r.kind = KIND_HEADER;
    end else if (t == REQ_TRAILER) begin
      if ($signed(w) < $signed(prev_time)) wraps = wraps + 32'd1;
      prev_time = w;
      r.ext_time = w + day_len * wraps;
      r.kind = KIND_TRAILER;
    end else begin
      dup = back_valid[1] && (back_two == w);
      r.channel = w[31:26];
      back_two = back_one;
      back_one = w;
      back_valid = {back_valid[0], 1'b1};
      roc = w[25:21];
      if (dup) begin
        r.kind = KIND_DUPLICATE;
      end else if (w[27:0] == '0) begin
        r.kind = KIND_NULL;
        other_seen = sat_inc(other_seen);
      end else if (roc > ROC_LAST_PIXEL) begin
        if (w == '1) begin
          r.kind = KIND_ALL_ONES;
          other_seen = sat_inc(other_seen);
        end else begin
          case (roc)
            ROC_GAP: begin
              r.kind = KIND_GAP;
              gaps_seen = sat_inc(gaps_seen);
            end
            ROC_DUMMY: begin
              r.kind = KIND_DUMMY;
              gaps_seen = sat_inc(gaps_seen);
            end
            ROC_NEARFULL: begin
              r.kind = KIND_NEARFULL;
              other_seen = sat_inc(other_seen);
            end
            ROC_TIMEOUT: begin
              tmo_seen = sat_inc(tmo_seen);
              if (w[27:20] == TIMEOUT_W1_SEL) begin
                r.kind = KIND_TIMEOUT_W1;
              end else if (w[27:20] == TIMEOUT_W2_SEL) begin
                r.kind = KIND_TIMEOUT_W2;
                off = TIMEOUT_OFFSET[w[10:8]];
                for (int i = 0; i < 5; i++)
                  if (w[i]) r.detail[off + i] = 1'b1;
              end else begin
                r.kind = KIND_TIMEOUT_OTH;
              end
            end
            ROC_TRAILER: begin
              r.kind = KIND_TRAILER_ERR;
              r.detail = {24'd0, w[11:0]};
              other_seen = sat_inc(other_seen);
            end
            default: begin
              r.kind = KIND_EVNUM_ERR;
              r.detail = {28'd0, w[7:0]};
              evnum_seen = sat_inc(evnum_seen);
            end
          endcase
        end
      end else if (r.channel != '0 && r.channel <= max_channel) begin
        idx = roc - 5'd1;
        if (roc != '0 && idx <= max_roc) begin
          pix = w[15:8];
          half = pix[7:1];
          r.kind = KIND_HIT;
          r.roc_index = idx[1:0];
          r.column = {w[20:16], pix[0]};
          r.row = (half >= 7'd80) ? half - 7'd80 : 7'd80 - half;
          hits_seen = sat_inc(hits_seen);
        end else begin
          r.kind = KIND_BAD_ROC;
          other_seen = sat_inc(other_seen);
        end
      end else begin
        r.kind = KIND_BAD_CHANNEL;
        other_seen = sat_inc(other_seen);
      end
    end
    r.hits       = hits_seen;
    r.gaps       = gaps_seen;
    r.timeouts   = tmo_seen;
    r.evnum_errs = evnum_seen;
    r.other_errs = other_seen;
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    decoded_t got;
    decoded_t want;
    if (!rst && pop && !empty) begin
      got.kind       = kind;
      got.channel    = channel;
      got.roc_index  = roc_index;
      got.column     = column;
      got.row        = row;
      got.detail     = detail;
      got.hits       = hit_count;
      got.gaps       = gap_count;
      got.timeouts   = timeout_count;
      got.evnum_errs = evnum_err_count;
      got.other_errs = other_err_count;
      got.ext_time   = extended_time;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: kind %0d channel %0d detail %h", kind, channel, detail);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("expected: kind %0d ch %0d roc %0d col %0d row %0d det %h",
                     want.kind, want.channel, want.roc_index, want.column, want.row,
                     want.detail);
            $display("          cnt %0d %0d %0d %0d %0d time %h", want.hits, want.gaps,
                     want.timeouts, want.evnum_errs, want.other_errs, want.ext_time);
            $display("actual:   kind %0d ch %0d roc %0d col %0d row %0d det %h",
                     got.kind, got.channel, got.roc_index, got.column, got.row,
                     got.detail);
            $display("          cnt %0d %0d %0d %0d %0d time %h", got.hits, got.gaps,
                     got.timeouts, got.evnum_errs, got.other_errs, got.ext_time);
          end
        end
      end
      pop_wait = rx_quiet ? 0 : $urandom_range(0, 14);
    end
  end

  always @(negedge clk) begin
    if (rst || hold_off || pop_wait > 0) pop <= 1'b0;
    else pop <= 1'b1;
    if (!rst && !hold_off && pop_wait > 0) pop_wait = pop_wait - 1;
  end

  initial begin : receiver_hold
    forever begin
      wait (hold_req);
      @(posedge clk);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off = 1'b0;
      hold_req = 1'b0;
    end
  end

  task automatic send_word(input logic [1:0] t, input logic [31:0] w);
    int idle;
    idle = tx_quiet ? 0 : $urandom_range(0, 14);
    if (idle > 0) begin
      push <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    push <= 1'b1;
    req_type <= t;
    word <= w;
    do @(posedge clk); while (full);
    pending_results.push_back(decode_word(t, w));
    @(negedge clk);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LAST_VALID_CHANNEL: max_channel = value[5:0];
      REG_LAST_VALID_ROC:     max_roc = value[4:0];
      default:                day_len = value;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_data_word();
    logic [31:0] r;
    int          top_chan;
    int          top_roc;
    r = $urandom;
    top_chan = (max_channel + 2 > 63) ? 63 : max_channel + 2;
    top_roc = (max_roc + 3 > 25) ? 25 : max_roc + 3;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6:
        return {6'($urandom_range(0, top_chan)), 5'($urandom_range(0, top_roc)), r[20:0]};
      7:  return {r[31:26], 5'($urandom_range(ROC_GAP, ROC_EVNUM)), r[20:0]};
      8:  return {r[31:28], TIMEOUT_W1_SEL, r[19:0]};
      9:  return {r[31:28], TIMEOUT_W2_SEL, r[19:0]};
      10: return {r[31:28], 28'd0};
      11: return '1;
      default: return r;
    endcase
  endfunction

  task automatic send_random_events(input int count);
    int          sent;
    int          n_data;
    int          data_idx;
    logic [31:0] w;
    logic [31:0] prior1;
    logic [31:0] prior2;
    sent = 0;
    while (sent < count) begin
      tx_quiet = ($urandom_range(0, 7) == 0);
      rx_quiet = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) != 0) begin
        send_word(REQ_HEADER, $urandom);
        n_data = $urandom_range(0, 24);
        data_idx = 0;
        prior1 = '0;
        prior2 = '0;
        repeat (n_data) begin
          if (data_idx >= 2 && $urandom_range(0, 7) == 0) w = prior2;
          else w = pick_data_word();
          send_word(($urandom_range(0, 15) == 0) ? REQ_SPARE : REQ_DATA, w);
          prior2 = prior1;
          prior1 = w;
          data_idx++;
        end
        case ($urandom_range(0, 9))
          0:       trailer_clock = $urandom;
          1:       trailer_clock = trailer_clock - $urandom_range(1, 1000);
          default: trailer_clock = trailer_clock + $urandom_range(0, 2000000);
        endcase
        send_word(REQ_TRAILER, trailer_clock);
        sent += n_data + 2;
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_word(2'($urandom_range(0, 3)), $urandom);
          sent++;
        end
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_special_words();
    send_word(REQ_HEADER, 32'h0);
    send_word(REQ_DATA, {6'd1, 5'd1, 5'd0, 8'd0, 8'h00});
    send_word(REQ_DATA, {6'd36, 5'd3, 5'd31, 8'd255, 8'hFF});
    send_word(REQ_DATA, {6'd2, 5'd2, 5'd10, 8'd160, 8'h00});
    send_word(REQ_DATA, {6'd2, 5'd2, 5'd11, 8'd161, 8'h00});
    send_word(REQ_DATA, {6'd37, 5'd1, 5'd4, 8'd20, 8'h00});
    send_word(REQ_DATA, {6'd0, 5'd2, 5'd4, 8'd20, 8'h00});
    send_word(REQ_DATA, {6'd63, 5'd2, 5'd4, 8'd21, 8'h00});
    send_word(REQ_DATA, {6'd5, 5'd0, 5'd3, 8'd40, 8'h00});
    send_word(REQ_DATA, {6'd5, 5'd4, 5'd3, 8'd40, 8'h00});
    send_word(REQ_DATA, {6'd5, ROC_LAST_PIXEL, 5'd3, 8'd41, 8'h00});
    send_word(REQ_DATA, {6'd1, ROC_GAP, 21'h0});
    send_word(REQ_DATA, {6'd1, ROC_DUMMY, 21'h0});
    send_word(REQ_DATA, {6'd2, ROC_NEARFULL, 21'h00055});
    send_word(REQ_DATA, {4'h0, TIMEOUT_W1_SEL, 20'h00000});
    send_word(REQ_DATA, {4'h5, TIMEOUT_W2_SEL, 9'h0, 3'd7, 3'd0, 5'h1F});
    send_word(REQ_DATA, {4'hA, TIMEOUT_W2_SEL, 9'h1FF, 3'd0, 3'd7, 5'h15});
    send_word(REQ_DATA, {6'd3, ROC_TIMEOUT, 21'h12345});
    send_word(REQ_DATA, {6'd7, ROC_TRAILER, 21'h00ABC});
    send_word(REQ_DATA, {6'd9, ROC_EVNUM, 21'h1F0F5});
    send_word(REQ_DATA, 32'hFFFF_FFFF);
    send_word(REQ_DATA, 32'hFC00_0000);
    send_word(REQ_DATA, 32'h0000_0000);
    send_word(REQ_SPARE, {6'd4, 5'd1, 5'd7, 8'd100, 8'h3C});
    send_word(REQ_TRAILER, 32'd12345);
    settle();
  endtask

  task automatic test_duplicate_history();
    logic [31:0] a;
    logic [31:0] b;
    a = {6'd1, 5'd1, 21'h00100};
    b = {6'd1, 5'd2, 21'h00200};
    send_word(REQ_HEADER, 32'h0);
    send_word(REQ_DATA, a);
    send_word(REQ_DATA, b);
    send_word(REQ_DATA, a);
    send_word(REQ_DATA, b);
    send_word(REQ_TRAILER, 32'd20000);
    send_word(REQ_DATA, a);
    send_word(REQ_HEADER, 32'h0);
    send_word(REQ_DATA, a);
    send_word(REQ_DATA, b);
    send_word(REQ_HEADER, 32'h0);
    send_word(REQ_DATA, a);
    send_word(REQ_DATA, b);
    settle();
  endtask

  task automatic test_trailer_wraps();
    send_word(REQ_HEADER, 32'h0);
    send_word(REQ_TRAILER, 32'd0);
    send_word(REQ_TRAILER, 32'd1000);
    send_word(REQ_TRAILER, 32'd999);
    send_word(REQ_TRAILER, 32'h7FFF_FFFF);
    send_word(REQ_TRAILER, 32'h8000_0000);
    send_word(REQ_TRAILER, 32'hFFFF_FFFF);
    send_word(REQ_TRAILER, 32'hFFFF_FFFF);
    send_word(REQ_TRAILER, 32'd5);
    settle();
    trailer_clock = 32'd5;
  endtask

  task automatic test_register_settings();
    logic [5:0]  chan_set [7];
    logic [4:0]  roc_set  [7];
    logic [31:0] day_set  [7];
    chan_set = '{6'd36, 6'd63, 6'd1, 6'd63, 6'd1, 6'd20, LAST_VALID_CHANNEL_RST};
    roc_set  = '{5'd2, 5'd31, 5'd0, 5'd0, 5'd31, 5'd3, LAST_VALID_ROC_RST};
    day_set  = '{32'd86400000, 32'hFFFF_FFFF, 32'd0, 32'd1, $urandom, $urandom,
                 DAY_LENGTH_RST};
    for (int i = 0; i < 7; i++) begin
      settle();
      write_register(REG_LAST_VALID_CHANNEL, {26'd0, chan_set[i]});
      write_register(REG_LAST_VALID_ROC, {27'd0, roc_set[i]});
      write_register(REG_DAY_LENGTH, day_set[i]);
      send_random_events(170);
    end
    settle();
  endtask

  task automatic test_input_backpressure();
    tx_quiet = 1'b1;
    hold_req = 1'b1;
    send_word(REQ_HEADER, 32'h0);
    repeat (38) send_word(REQ_DATA, pick_data_word());
    trailer_clock = trailer_clock + 32'd777;
    send_word(REQ_TRAILER, trailer_clock);
    tx_quiet = 1'b0;
    settle();
  endtask

  task automatic test_random_traffic();
    send_random_events(300);
    settle();
  endtask

  initial begin : run
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_special_words();
    test_duplicate_history();
    test_trailer_wraps();
    test_register_settings();
    test_input_backpressure();
    test_random_traffic();
    settle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
